// ----- sv/hlmd_pkg.sv -----
// ----------------------------------------------------------------------------
// hlmd_pkg: shared constants for the heightmap low-point detector
// Field widths, register indexes, reset sizes and result slot codes.
// ----------------------------------------------------------------------------
package hlmd_pkg;

    // Payload field widths
    localparam int HEIGHT_W = 4;
    localparam int POS_W    = 7;
    localparam int RISK_W   = 19;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Saturation value of the running risk sum
    localparam logic [RISK_W-1:0] RISK_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Grid size after reset
    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 8'd100;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 8'd100;

    // Result slots of one input: cell above, cell to the left, the cell itself
    typedef enum logic [1:0] {
        SLOT_UP   = 2'd0,
        SLOT_LEFT = 2'd1,
        SLOT_SELF = 2'd2
    } slot_t;

endpackage

// ----- sv/heightmap_local_minimum_detector_top.sv -----
// ----------------------------------------------------------------------------
// heightmap_local_minimum_detector_top: streaming 4-neighbour low-point finder
// Judges each cell of a raster-order height map once its last neighbour has
// arrived and keeps a per-frame risk sum over the low points.
// ----------------------------------------------------------------------------
// Cells enter one per clock in raster order unless in_stall holds them.
// Two line buffers (the row above and the row above that) sit in
// single-port-write memories with a registered read; every request writes
// both buffers at its column, reads the row above one column ahead and the
// older row at its own column, so no forwarding is needed. Outside the last
// row each request judges at most one cell and the block sustains one
// request per clock while the receiver does not stall; in the last row a
// request can judge two cells and the frame's final request three, and
// in_stall holds the sender while the single output register hands out one
// result per clock. The line buffers need no clearing pass: no legal stream
// reads an entry before writing it. grid_width and grid_height are clamped
// to 2..MAX_WIDTH and 2..MAX_ROWS; write them only while the block is idle.
module heightmap_local_minimum_detector_top #(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_ROWS  = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [hlmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hlmd_pkg::CFG_W-1:0]          cfg_data,
    // input cells
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hlmd_pkg::HEIGHT_W-1:0]       cell_height,
    input  logic                                frame_start,
    // judged cells
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hlmd_pkg::POS_W-1:0]          judged_row,
    output logic [hlmd_pkg::POS_W-1:0]          judged_col,
    output logic [hlmd_pkg::HEIGHT_W-1:0]       judged_height,
    output logic                                is_low_point,
    output logic [hlmd_pkg::RISK_W-1:0]         risk_total,
    output logic                                last_of_run,
    output logic                                frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int EW0 = $clog2(MAX_WIDTH + 1);
    localparam int EW1 = $clog2(MAX_ROWS + 1);
    localparam int EW2 = (EW0 > EW1) ? EW0 : EW1;
    localparam int EW  = (EW2 > hlmd_pkg::CFG_W) ? EW2 : hlmd_pkg::CFG_W;
    localparam int HW  = hlmd_pkg::HEIGHT_W;

    // ------------------------------------------------------------------
    // Configuration registers and clamped sizes
    // ------------------------------------------------------------------
    logic [hlmd_pkg::CFG_W-1:0] grid_width_reg;
    logic [hlmd_pkg::CFG_W-1:0] grid_height_reg;
    logic [EW-1:0]              w_cfg, h_cfg, w_eff, h_eff, w_last, h_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= hlmd_pkg::GRID_WIDTH_RST;
            grid_height_reg <= hlmd_pkg::GRID_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hlmd_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                hlmd_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes to the supported range
    always_comb
    begin
        w_cfg = EW'(grid_width_reg);
        h_cfg = EW'(grid_height_reg);
        if (w_cfg < EW'(2))
            w_eff = EW'(2);
        else if (w_cfg > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = w_cfg;
        if (h_cfg < EW'(2))
            h_eff = EW'(2);
        else if (h_cfg > EW'(MAX_ROWS))
            h_eff = EW'(MAX_ROWS);
        else
            h_eff = h_cfg;
        w_last = w_eff - EW'(1);
        h_last = h_eff - EW'(1);
    end

    // ------------------------------------------------------------------
    // Request side: position counters and neighbour history
    // ------------------------------------------------------------------
    logic          in_acc;
    logic          b_adv;
    logic [RW-1:0] row_reg, row_next, r_cur;
    logic [CW-1:0] col_reg, col_next, c_cur, c_ahead;
    logic          restart, c_is_last, r_is_last;
    logic [HW-1:0] prev_q_reg, older_q_reg;
    logic [HW-1:0] ul_reg, left_reg, left2_reg;

    assign in_acc = in_valid && !in_stall;

    always_comb
    begin
        restart = frame_start || (EW'(row_reg) >= h_eff) || (EW'(col_reg) >= w_eff);
        r_cur   = restart ? '0 : row_reg;
        c_cur   = restart ? '0 : col_reg;
        c_is_last = (EW'(c_cur) == w_last);
        r_is_last = (EW'(r_cur) == h_last);
        c_ahead = c_is_last ? '0 : c_cur + CW'(1);
        if (c_is_last)
        begin
            col_next = '0;
            row_next = r_is_last ? '0 : r_cur + RW'(1);
        end
        else
        begin
            col_next = c_ahead;
            row_next = r_cur;
        end
    end

    // Advance counters on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Shift the horizontal history: upper-left, left, left-of-left
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ul_reg    <= prev_q_reg;
            left_reg  <= cell_height;
            left2_reg <= left_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: write this column, read the row above one column ahead
    // ------------------------------------------------------------------
    logic [HW-1:0] prev_mem  [MAX_WIDTH];
    logic [HW-1:0] older_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            prev_mem[c_cur]  <= cell_height;
            older_mem[c_cur] <= prev_q_reg;
            prev_q_reg       <= prev_mem[c_ahead];
            older_q_reg      <= older_mem[c_cur];
        end
    end

    // ------------------------------------------------------------------
    // Evaluate stage: memory data arrives, compare neighbours
    // ------------------------------------------------------------------
    logic          b_valid_reg, b_valid_next;
    logic [RW-1:0] b_r_reg;
    logic [CW-1:0] b_c_reg;
    logic [HW-1:0] b_v_reg, b_pu_reg, b_ul_reg, b_left_reg, b_left2_reg;
    logic          b_r_ge1_reg, b_r_ge2_reg, b_c_gt0_reg, b_c_ge2_reg;
    logic          b_c_not_last_reg, b_row_last_reg, b_col_last_reg, b_clr_reg;
    logic          low0, low1, low2;
    logic [2:0]    b_mask;
    logic          c_free;

    assign b_adv        = b_valid_reg && c_free;
    assign in_stall     = b_valid_reg && !c_free;
    assign b_valid_next = in_acc || (b_valid_reg && !c_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    // Capture the request and its position flags
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_r_reg          <= r_cur;
            b_c_reg          <= c_cur;
            b_v_reg          <= cell_height;
            b_pu_reg         <= prev_q_reg;
            b_ul_reg         <= ul_reg;
            b_left_reg       <= left_reg;
            b_left2_reg      <= left2_reg;
            b_r_ge1_reg      <= (r_cur != '0);
            b_r_ge2_reg      <= (EW'(r_cur) > EW'(1));
            b_c_gt0_reg      <= (c_cur != '0);
            b_c_ge2_reg      <= (EW'(c_cur) > EW'(1));
            b_c_not_last_reg <= !c_is_last;
            b_row_last_reg   <= r_is_last;
            b_col_last_reg   <= c_is_last;
            b_clr_reg        <= (r_cur == '0) && (c_cur == '0);
        end
    end

    // Judge the cell above, the cell to the left and the cell itself
    always_comb
    begin
        low0 = !(b_r_ge2_reg && (older_q_reg <= b_pu_reg))
            && !(b_v_reg <= b_pu_reg)
            && !(b_c_gt0_reg && (b_ul_reg <= b_pu_reg))
            && !(b_c_not_last_reg && (prev_q_reg <= b_pu_reg));
        low1 = !(b_ul_reg <= b_left_reg)
            && !(b_c_ge2_reg && (b_left2_reg <= b_left_reg))
            && !(b_v_reg <= b_left_reg);
        low2 = !(b_pu_reg <= b_v_reg) && !(b_left_reg <= b_v_reg);
        b_mask = {b_row_last_reg && b_col_last_reg,
                  b_row_last_reg && b_c_gt0_reg,
                  b_r_ge1_reg};
    end

    // ------------------------------------------------------------------
    // Result sequencer: unless out_stall holds them, hand out pending results one per clock
    // ------------------------------------------------------------------
    logic [2:0]          c_mask_reg, c_mask_next, mask_rest;
    logic [RW-1:0]       c_r_reg;
    logic [CW-1:0]       c_c_reg;
    logic [HW-1:0]       c_v_reg, c_pu_reg, c_left_reg;
    logic [2:0]          c_low_reg;
    logic                out_load;
    hlmd_pkg::slot_t     slot;
    logic [RW-1:0]       s_row;
    logic [CW-1:0]       s_col;
    logic [HW-1:0]       s_h;
    logic                s_low, s_done;
    logic                out_valid_reg, out_valid_next;

    assign mask_rest = c_mask_reg & (c_mask_reg - 3'd1);
    assign out_load  = (!out_valid_reg || !out_stall) && (c_mask_reg != 3'd0);
    assign c_free    = (c_mask_reg == 3'd0) || (out_load && (mask_rest == 3'd0));

    always_comb
    begin
        if (b_adv)
            c_mask_next = b_mask;
        else if (out_load)
            c_mask_next = mask_rest;
        else
            c_mask_next = c_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_mask_reg <= 3'd0;
        else
            c_mask_reg <= c_mask_next;
    end

    // Load the judged request into the sequencer
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            c_r_reg    <= b_r_reg;
            c_c_reg    <= b_c_reg;
            c_v_reg    <= b_v_reg;
            c_pu_reg   <= b_pu_reg;
            c_left_reg <= b_left_reg;
            c_low_reg  <= {low2, low1, low0};
        end
    end

    // Pick the oldest pending result
    always_comb
    begin
        if (c_mask_reg[0])
            slot = hlmd_pkg::SLOT_UP;
        else if (c_mask_reg[1])
            slot = hlmd_pkg::SLOT_LEFT;
        else
            slot = hlmd_pkg::SLOT_SELF;
        case (slot)
            hlmd_pkg::SLOT_UP:
            begin
                s_row  = c_r_reg - RW'(1);
                s_col  = c_c_reg;
                s_h    = c_pu_reg;
                s_low  = c_low_reg[0];
                s_done = 1'b0;
            end
            hlmd_pkg::SLOT_LEFT:
            begin
                s_row  = c_r_reg;
                s_col  = c_c_reg - CW'(1);
                s_h    = c_left_reg;
                s_low  = c_low_reg[1];
                s_done = 1'b0;
            end
            default:
            begin
                s_row  = c_r_reg;
                s_col  = c_c_reg;
                s_h    = c_v_reg;
                s_low  = c_low_reg[2];
                s_done = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Risk accumulator: saturating sum, cleared at the frame's first cell
    // ------------------------------------------------------------------
    logic [hlmd_pkg::RISK_W-1:0] acc_reg, acc_next, acc_emit, acc_upd;
    logic [hlmd_pkg::RISK_W:0]   acc_sum;
    logic                        clr_load;

    assign clr_load = b_adv && b_clr_reg;

    always_comb
    begin
        acc_sum  = {1'b0, acc_reg} + (hlmd_pkg::RISK_W + 1)'(s_h)
                 + (hlmd_pkg::RISK_W + 1)'(1);
        acc_upd  = acc_sum[hlmd_pkg::RISK_W] ? hlmd_pkg::RISK_MAX
                                             : acc_sum[hlmd_pkg::RISK_W-1:0];
        acc_emit = (out_load && s_low) ? acc_upd : acc_reg;
        acc_next = clr_load ? '0 : acc_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    // ------------------------------------------------------------------
    // Output register: holds a result while the receiver stalls
    // ------------------------------------------------------------------
    logic [hlmd_pkg::POS_W-1:0]    judged_row_reg, judged_col_reg;
    logic [HW-1:0]                 judged_height_reg;
    logic                          is_low_point_reg, last_of_run_reg, frame_done_reg;
    logic [hlmd_pkg::RISK_W-1:0]   risk_total_reg;
    logic [31:0]                   row_wide, col_wide;

    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign row_wide = 32'(s_row);
    assign col_wide = 32'(s_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            judged_row_reg    <= row_wide[hlmd_pkg::POS_W-1:0];
            judged_col_reg    <= col_wide[hlmd_pkg::POS_W-1:0];
            judged_height_reg <= s_h;
            is_low_point_reg  <= s_low;
            risk_total_reg    <= acc_emit;
            last_of_run_reg   <= (mask_rest == 3'd0);
            frame_done_reg    <= s_done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign judged_row    = judged_row_reg;
    assign judged_col    = judged_col_reg;
    assign judged_height = judged_height_reg;
    assign is_low_point  = is_low_point_reg;
    assign risk_total    = risk_total_reg;
    assign last_of_run   = last_of_run_reg;
    assign frame_done    = frame_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The frame's last cell always closes its request's run of results
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!frame_done_reg || last_of_run_reg))
        else $error("frame_done result without last_of_run");

    // Line buffer read data must hold while the evaluate stage waits
    a_mem_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !c_free) |=> ((prev_q_reg === $past(prev_q_reg))
                                     && (older_q_reg === $past(older_q_reg))))
        else $error("line buffer data changed under a waiting request");

    // The risk sum only grows within a frame
    a_risk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_load |=> (acc_reg >= $past(acc_reg)))
        else $error("risk sum decreased without a frame restart");

endmodule

// ----- verif/heightmap_local_minimum_detector_top_tb.sv -----
// ----------------------------------------------------------------------------
// heightmap_local_minimum_detector_top_tb: self-checking bench for the detector
// Streams height-map frames through the block under random sender gaps and
// receiver stalls. A behavioral line-buffer model in the bench predicts every
// judged cell, and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module heightmap_local_minimum_detector_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX    = 128;
    localparam int SETTLE_CYC  = 8;
    localparam int HOLD_CYC    = 200;
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT_NS  = 5_000_000;

    // Ways to fill a frame with heights
    typedef enum int {
        HT_UNIFORM = 0,
        HT_TIES    = 1,
        HT_DIPS    = 2,
        HT_FLAT    = 3,
        HT_RISING  = 4,
        HT_FALLING = 5
    } height_style_t;

    typedef struct packed {
        logic [hlmd_pkg::POS_W-1:0]    row;
        logic [hlmd_pkg::POS_W-1:0]    col;
        logic [hlmd_pkg::HEIGHT_W-1:0] height;
        logic                          low_flag;
        logic [hlmd_pkg::RISK_W-1:0]   risk;
        logic                          last_of_run;
        logic                          frame_done;
    } judgement_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [hlmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hlmd_pkg::CFG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [hlmd_pkg::HEIGHT_W-1:0]  cell_height;
    logic                           frame_start;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [hlmd_pkg::POS_W-1:0]     judged_row;
    logic [hlmd_pkg::POS_W-1:0]     judged_col;
    logic [hlmd_pkg::HEIGHT_W-1:0]  judged_height;
    logic                           is_low_point;
    logic [hlmd_pkg::RISK_W-1:0]    risk_total;
    logic                           last_of_run;
    logic                           frame_done;

    // Bench-side copy of the detector state
    logic [hlmd_pkg::HEIGHT_W-1:0]  line_above [GRID_MAX];
    logic [hlmd_pkg::HEIGHT_W-1:0]  line_above2 [GRID_MAX];
    int unsigned                    cur_row;
    int unsigned                    cur_col;
    logic [hlmd_pkg::HEIGHT_W-1:0]  left_h;
    logic [hlmd_pkg::HEIGHT_W-1:0]  upper_left_h;
    logic [hlmd_pkg::RISK_W-1:0]    risk_sum;
    logic [hlmd_pkg::CFG_W-1:0]     width_reg;
    logic [hlmd_pkg::CFG_W-1:0]     height_reg;

    judgement_t           expected_judgements [$];
    int                   judgement_errors = 0;
    int                   cells_sent = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    logic                 hold_active = 1'b0;
    event                 hold_start;

    heightmap_local_minimum_detector_top #(
        .MAX_WIDTH(GRID_MAX),
        .MAX_ROWS (GRID_MAX)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_height  (cell_height),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .judged_row   (judged_row),
        .judged_col   (judged_col),
        .judged_height(judged_height),
        .is_low_point (is_low_point),
        .risk_total   (risk_total),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a size register to the range the block honors
    function automatic int unsigned effective_size(input logic [hlmd_pkg::CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > GRID_MAX)
            return GRID_MAX;
        return v;
    endfunction

    // Build one judgement and fold a low point into the frame's risk sum
    function automatic judgement_t score_cell(input int unsigned r, input int unsigned c,
                                              input logic [hlmd_pkg::HEIGHT_W-1:0] hgt,
                                              input logic low, input logic done);
        judgement_t j;
        logic [hlmd_pkg::RISK_W:0] sum;
        if (low)
        begin
            sum = {1'b0, risk_sum} + (hlmd_pkg::RISK_W + 1)'(hgt)
                + (hlmd_pkg::RISK_W + 1)'(1);
            risk_sum = (sum > hlmd_pkg::RISK_MAX) ? hlmd_pkg::RISK_MAX
                                                  : sum[hlmd_pkg::RISK_W-1:0];
        end
        j.row         = r[hlmd_pkg::POS_W-1:0];
        j.col         = c[hlmd_pkg::POS_W-1:0];
        j.height      = hgt;
        j.low_flag    = low;
        j.risk        = risk_sum;
        j.last_of_run = 1'b0;
        j.frame_done  = done;
        return j;
    endfunction

    // Judge every cell that the arriving one completes and queue the results
    task automatic judge_cell_arrival(input logic [hlmd_pkg::HEIGHT_W-1:0] v,
                                      input logic fs);
        int unsigned w, h, r, c, n, i;
        logic [hlmd_pkg::HEIGHT_W-1:0] pu, ou;
        logic low;
        judgement_t found [3];
        w = effective_size(width_reg);
        h = effective_size(height_reg);
        n = 0;
        if (fs || cur_row >= h || cur_col >= w)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        if (r == 0 && c == 0)
            risk_sum = '0;
        pu = line_above[c];
        ou = line_above2[c];
        // cell above: its last neighbour just arrived
        if (r >= 1)
        begin
            low = 1'b1;
            if (r >= 2 && ou <= pu)
                low = 1'b0;
            if (v <= pu)
                low = 1'b0;
            if (c > 0 && upper_left_h <= pu)
                low = 1'b0;
            if (c + 1 < w && line_above[c + 1] <= pu)
                low = 1'b0;
            found[n] = score_cell(r - 1, c, pu, low, 1'b0);
            n++;
        end
        // last row: the cell to the left is complete
        if (r == h - 1 && c >= 1)
        begin
            low = 1'b1;
            if (upper_left_h <= left_h)
                low = 1'b0;
            if (c >= 2 && line_above[c - 2] <= left_h)
                low = 1'b0;
            if (v <= left_h)
                low = 1'b0;
            found[n] = score_cell(r, c - 1, left_h, low, 1'b0);
            n++;
        end
        // frame's last cell judges itself
        if (r == h - 1 && c == w - 1)
        begin
            low = 1'b1;
            if (pu <= v)
                low = 1'b0;
            if (left_h <= v)
                low = 1'b0;
            found[n] = score_cell(r, c, v, low, 1'b1);
            n++;
        end
        if (n > 0)
            found[n - 1].last_of_run = 1'b1;
        for (i = 0; i < n; i++)
            expected_judgements.push_back(found[i]);
        // advance line buffers and position
        line_above2[c] = pu;
        line_above[c]  = v;
        upper_left_h   = pu;
        left_h         = v;
        if (c + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endtask

    function automatic logic [hlmd_pkg::HEIGHT_W-1:0] pick_height(input height_style_t style,
                                                                  input int idx);
        case (style)
            HT_TIES:
                return (hlmd_pkg::HEIGHT_W)'($urandom_range(6, 8));
            HT_DIPS:
                return ($urandom_range(0, 3) == 0) ?
                       (hlmd_pkg::HEIGHT_W)'($urandom_range(0, 4)) :
                       (hlmd_pkg::HEIGHT_W)'($urandom_range(10, 15));
            HT_FLAT:
                return 4'd7;
            HT_RISING:
                return idx[hlmd_pkg::HEIGHT_W-1:0];
            HT_FALLING:
                return 4'd15 - idx[hlmd_pkg::HEIGHT_W-1:0];
            default:
                return (hlmd_pkg::HEIGHT_W)'($urandom_range(0, 15));
        endcase
    endfunction

    // Offer one cell and hold it until the block takes it
    task automatic send_cell(input logic [hlmd_pkg::HEIGHT_W-1:0] h, input logic fs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cell_height <= h;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        judge_cell_arrival(h, fs);
        cells_sent++;
    endtask

    task automatic send_cells(input int count, input height_style_t style,
                              input logic fs_first, input int fs_noise_pct);
        int i;
        logic fs;
        for (i = 0; i < count; i++)
        begin
            fs = (i == 0) ? fs_first : ($urandom_range(0, 99) < fs_noise_pct);
            send_cell(pick_height(style, i), fs);
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_judgements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write both size registers while the block is idle
    task automatic write_grid_size(input logic [hlmd_pkg::CFG_W-1:0] w_val,
                                   input logic [hlmd_pkg::CFG_W-1:0] h_val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= hlmd_pkg::REG_GRID_WIDTH;
        cfg_data  <= w_val;
        @(posedge clk);
        width_reg = w_val;
        cfg_index <= hlmd_pkg::REG_GRID_HEIGHT;
        cfg_data  <= h_val;
        @(posedge clk);
        height_reg = h_val;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [hlmd_pkg::CFG_W-1:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return (hlmd_pkg::CFG_W)'($urandom_range(0, 1));
        if (sel == 1)
            return (hlmd_pkg::CFG_W)'($urandom_range(7, 8));
        return (hlmd_pkg::CFG_W)'($urandom_range(2, 5));
    endfunction

    // Compare one result against the oldest prediction
    task automatic check_judgement();
        judgement_t got, want;
        got.row         = judged_row;
        got.col         = judged_col;
        got.height      = judged_height;
        got.low_flag    = is_low_point;
        got.risk        = risk_total;
        got.last_of_run = last_of_run;
        got.frame_done  = frame_done;
        if (expected_judgements.size() == 0)
        begin
            judgement_errors++;
            if (judgement_errors <= MAX_REPORTS)
                $display("unexpected result: row %0d col %0d h %0d low %0b risk %0d",
                         got.row, got.col, got.height, got.low_flag, got.risk);
        end
        else
        begin
            want = expected_judgements.pop_front();
            if (got !== want)
            begin
                judgement_errors++;
                if (judgement_errors <= MAX_REPORTS)
                begin
                    $display({"mismatch: exp row %0d col %0d h %0d low %0b risk %0d",
                              " last %0b done %0b"},
                             want.row, want.col, want.height, want.low_flag, want.risk,
                             want.last_of_run, want.frame_done);
                    $display({"          got row %0d col %0d h %0d low %0b risk %0d",
                              " last %0b done %0b"},
                             got.row, got.col, got.height, got.low_flag, got.risk,
                             got.last_of_run, got.frame_done);
                end
            end
        end
    endtask

    // Result side: check accepted results, stall at random or on a long hold
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_judgement();
            out_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted in cycles
    initial
    begin
        forever
        begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYC) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Cells at the default 100x100 size, straight out of reset: a short first
    // row judges nothing
    task automatic test_reset_defaults();
        send_cells(12, HT_UNIFORM, 1'b0, 0);
        wait_idle();
    endtask

    // Clamped and extreme grid sizes
    task automatic test_size_extremes();
        write_grid_size(8'd0, 8'd1);
        send_cells(4, HT_FALLING, 1'b1, 0);
        send_cells(4, HT_RISING, 1'b0, 0);
        write_grid_size(8'd1, 8'd200);
        send_cells(8, HT_DIPS, 1'b1, 0);
    endtask

    // Ties, corner lows, wrap without frame_start, restarts and shrinking sizes
    task automatic test_special_cases();
        write_grid_size(8'd3, 8'd3);
        send_cells(9, HT_FLAT, 1'b1, 0);
        send_cells(9, HT_FALLING, 1'b0, 0);
        send_cells(5, HT_UNIFORM, 1'b1, 0);
        send_cells(9, HT_RISING, 1'b1, 0);
        // shrink width past the column counter
        write_grid_size(8'd4, 8'd4);
        send_cells(7, HT_UNIFORM, 1'b1, 0);
        write_grid_size(8'd3, 8'd4);
        send_cells(6, HT_DIPS, 1'b0, 0);
        // shrink height past the row counter
        write_grid_size(8'd3, 8'd2);
        send_cells(6, HT_UNIFORM, 1'b0, 0);
        wait_idle();
    endtask

    // Hold the result side off long enough to back the block up
    task automatic test_full_backpressure();
        write_grid_size(8'd5, 8'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_start;
        send_cells(22, HT_UNIFORM, 1'b1, 0);
        wait_idle();
    endtask

    // Random sizes and frames: mostly whole frames, some cut short or noisy
    task automatic test_random_frames(input int send_pct, input int stall_pct,
                                      input int quota);
        int start_count, frames, kind;
        int unsigned w, h;
        logic need_fs;
        height_style_t style;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start_count    = cells_sent;
        while (cells_sent - start_count < quota)
        begin
            write_grid_size(pick_size(), pick_size());
            w = effective_size(width_reg);
            h = effective_size(height_reg);
            need_fs = 1'b1;
            frames = $urandom_range(1, 2);
            repeat (frames)
            begin
                kind  = $urandom_range(0, 9);
                style = height_style_t'($urandom_range(0, 5));
                if (kind < 7)
                begin
                    send_cells(w * h, style, need_fs || $urandom_range(0, 1), 0);
                    need_fs = 1'b0;
                end
                else if (kind == 7)
                begin
                    send_cells($urandom_range(1, w * h - 1), style, need_fs, 0);
                    need_fs = 1'b1;
                end
                else
                begin
                    send_cells(w * h, style, 1'b1, 15);
                    need_fs = 1'b1;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = hlmd_pkg::REG_GRID_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cell_height  = '0;
        frame_start  = 1'b0;
        cur_row      = 0;
        cur_col      = 0;
        left_h       = '0;
        upper_left_h = '0;
        risk_sum     = '0;
        width_reg    = hlmd_pkg::GRID_WIDTH_RST;
        height_reg   = hlmd_pkg::GRID_HEIGHT_RST;
        for (int i = 0; i < GRID_MAX; i++)
        begin
            line_above[i]  = '0;
            line_above2[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_size_extremes();
        test_special_cases();
        test_full_backpressure();
        test_random_frames(0, 0, 12);
        test_random_frames(81, 0, 12);
        test_random_frames(0, 81, 12);
        test_random_frames(35, 35, 12);

        wait_idle();
        if (judgement_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
